@@ rtl/blm_pkg.sv @@
// Shared types and constants for the battery level monitor.
`timescale 1ns / 1ps
package blm_pkg;

  localparam int FACTOR_W = 16;
  localparam int THR_W    = 12;
  localparam int SCALE_W  = 14;
  localparam int VOLT_W   = 16;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 4;

  localparam logic [SCALE_W-1:0] SCALE_NUM = 14'd10000;
  localparam logic [VOLT_W-1:0]  VOLT_MAX  = 16'hFFFF;

  // register indexes on the configuration port
  localparam logic [1:0] REG_VOLTAGE_FACTOR          = 2'd0;
  localparam logic [1:0] REG_CHARGING_VOLTAGE_FACTOR = 2'd1;
  localparam logic [1:0] REG_LOW_THRESHOLD           = 2'd2;
  localparam logic [1:0] REG_CRITICAL_THRESHOLD      = 2'd3;

  localparam logic [FACTOR_W-1:0] VOLTAGE_FACTOR_RST = 16'd7200;
  localparam logic [THR_W-1:0]    LOW_THRESHOLD_RST  = 12'd2650;
  localparam logic [THR_W-1:0]    CRIT_THRESHOLD_RST = 12'd2500;

  localparam logic [1:0] CHG_EVT_NONE       = 2'd0;
  localparam logic [1:0] CHG_EVT_CONNECT    = 2'd1;
  localparam logic [1:0] CHG_EVT_DISCONNECT = 2'd2;

  localparam logic [1:0] BAT_EVT_NONE     = 2'd0;
  localparam logic [1:0] BAT_EVT_CRITICAL = 2'd1;
  localparam logic [1:0] BAT_EVT_LOW      = 2'd2;

  typedef struct packed {
    logic [FACTOR_W-1:0] voltage_factor;
    logic [FACTOR_W-1:0] charging_voltage_factor;
    logic [THR_W-1:0]    low_threshold;
    logic [THR_W-1:0]    critical_threshold;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic init_div;
    logic step;
    logic publish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

@@ rtl/blm_ctrl.sv @@
// Sequencing state machine for the battery level monitor.
`timescale 1ns / 1ps
module blm_ctrl #(
  parameter int DIV_W = 26
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  blm_pkg::status_t  status,
  output blm_pkg::cmd_t     cmd
);
  import blm_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.init_div = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) state_next = S_DONE;
      end
      S_DONE: begin
        // hold the quotient until the output register is free
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  a_publish_needs_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> status.out_free)
    else $error("publish while output register occupied");

  a_div_follows_mul: assert property (@(posedge clk) disable iff (rst)
    cmd.init_div |=> cmd.step && cnt == '0)
    else $error("divider did not start after operand load");

  a_load_then_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !in_ready)
    else $error("input taken while a tick is in progress");

endmodule

@@ rtl/blm_datapath.sv @@
// Tick state, event logic, serial divider and result register.
`timescale 1ns / 1ps
module blm_datapath #(
  parameter int ADC_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  blm_pkg::cmd_t                cmd,
  output blm_pkg::status_t             status,
  input  blm_pkg::cfg_t                cfg,
  input  logic [ADC_BITS-1:0]          adc_sample,
  input  logic                         charger_level,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   charger_event,
  output logic [1:0]                   battery_event,
  output logic [blm_pkg::VOLT_W-1:0]   voltage_centivolts,
  output logic                         is_charging,
  output logic                         is_low,
  output logic                         is_critical,
  output logic [ADC_BITS-1:0]          lowest_sample
);
  import blm_pkg::*;

  localparam int DIV_W = ADC_BITS + SCALE_W;
  localparam int CMP_W = (ADC_BITS > THR_W) ? ADC_BITS : THR_W;

  // per-tick state
  logic                prev_charger;
  logic                low_reported;
  logic                critical_reported;
  logic [ADC_BITS-1:0] min_sample;

  // captured tick
  logic [ADC_BITS-1:0] sample_q;
  logic [1:0]          chg_evt_q, bat_evt_q;
  logic                chg_q, low_q, crit_q;
  logic [FACTOR_W-1:0] divisor;

  // divider
  logic [DIV_W-1:0]    quo;
  logic [FACTOR_W-1:0] rem;
  logic [FACTOR_W:0]   trial, diff;
  logic                take;
  logic [DIV_W-1:0]    prod;

  logic                in_low, in_crit, new_crit, new_low;
  logic [1:0]          chg_evt, bat_evt;
  logic [ADC_BITS-1:0] min_next;
  logic [VOLT_W-1:0]   volt;

  assign in_low  = CMP_W'(adc_sample) < CMP_W'(cfg.low_threshold);
  assign in_crit = CMP_W'(adc_sample) < CMP_W'(cfg.critical_threshold);
  assign new_crit = !charger_level && !critical_reported && in_crit;
  assign new_low  = !charger_level && !new_crit && !low_reported && in_low;

  always_comb begin
    priority if (charger_level && !prev_charger) chg_evt = CHG_EVT_CONNECT;
    else if (!charger_level && prev_charger)     chg_evt = CHG_EVT_DISCONNECT;
    else                                         chg_evt = CHG_EVT_NONE;
    priority if (new_crit) bat_evt = BAT_EVT_CRITICAL;
    else if (new_low)      bat_evt = BAT_EVT_LOW;
    else                   bat_evt = BAT_EVT_NONE;
  end

  assign min_next = (adc_sample < min_sample || charger_level) ? adc_sample : min_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_charger      <= 1'b0;
      low_reported      <= 1'b0;
      critical_reported <= 1'b0;
      min_sample        <= '1;
    end else if (cmd.load) begin
      prev_charger <= charger_level;
      min_sample   <= min_next;
      if (charger_level) begin
        // re-arm both one-shot events
        low_reported      <= 1'b0;
        critical_reported <= 1'b0;
      end else begin
        if (new_crit) critical_reported <= 1'b1;
        if (new_low)  low_reported      <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_q  <= adc_sample;
      chg_evt_q <= chg_evt;
      bat_evt_q <= bat_evt;
      chg_q     <= charger_level;
      low_q     <= in_low;
      crit_q    <= in_crit;
      divisor   <= charger_level ? cfg.charging_voltage_factor : cfg.voltage_factor;
    end
  end

  // restoring division, one quotient bit per step
  assign prod  = DIV_W'(sample_q) * DIV_W'(SCALE_NUM);
  assign trial = {rem, quo[DIV_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign take  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (cmd.init_div) begin
      quo <= prod;
      rem <= '0;
    end else if (cmd.step) begin
      quo <= {quo[DIV_W-2:0], take};
      rem <= take ? diff[FACTOR_W-1:0] : trial[FACTOR_W-1:0];
    end
  end

  // a zero divisor yields all ones, which saturates as well
  assign volt = (|quo[DIV_W-1:VOLT_W]) ? VOLT_MAX : quo[VOLT_W-1:0];

  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      charger_event      <= chg_evt_q;
      battery_event      <= bat_evt_q;
      voltage_centivolts <= volt;
      is_charging        <= chg_q;
      is_low             <= low_q;
      is_critical        <= crit_q;
      lowest_sample      <= min_sample;
    end
  end

  a_publish_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> out_valid)
    else $error("result lost after publish");

  a_no_bat_evt_charging: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_charging && battery_event != BAT_EVT_NONE))
    else $error("battery event raised while charging");

  a_crit_evt_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && battery_event == BAT_EVT_CRITICAL) |-> is_critical)
    else $error("critical event without critical sample");

  a_charge_resets_min: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && charger_level) |=> min_sample == $past(adc_sample))
    else $error("minimum not reset on charging tick");

endmodule

@@ rtl/battery_level_monitor.sv @@
// Top level of the battery level monitor: register file and core.
//
//  channel   handshake                    payload
//  input     in_valid / in_ready          adc_sample, charger_level
//  output    out_valid / out_ready        charger_event .. lowest_sample
//  config    psel/penable/pwrite, pready   paddr, pwdata, prdata
//
// A tick passes from transfer to valid result through a setup state, ADC_BITS + 14
// restoring divider steps of one quotient bit each, and a publish into the output register.
// A new tick is taken once the previous one has its result in the output register,
// so the block does not accept a new input transfer while a tick is in progress.
// A stalled output holds the result; the next tick still computes and waits.
// Synchronous reset restores all factors, thresholds and tracking state.
`timescale 1ns / 1ps
module battery_level_monitor #(
  parameter int ADC_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [blm_pkg::APB_AW-1:0]   paddr,
  input  logic [blm_pkg::APB_DW-1:0]   pwdata,
  output logic [blm_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ADC_BITS-1:0]          adc_sample,
  input  logic                         charger_level,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   charger_event,
  output logic [1:0]                   battery_event,
  output logic [blm_pkg::VOLT_W-1:0]   voltage_centivolts,
  output logic                         is_charging,
  output logic                         is_low,
  output logic                         is_critical,
  output logic [ADC_BITS-1:0]          lowest_sample
);
  import blm_pkg::*;

  localparam int DIV_W = ADC_BITS + SCALE_W;

  cfg_t       cfg;
  cmd_t       cmd;
  status_t    status;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.voltage_factor          <= VOLTAGE_FACTOR_RST;
      cfg.charging_voltage_factor <= VOLTAGE_FACTOR_RST;
      cfg.low_threshold           <= LOW_THRESHOLD_RST;
      cfg.critical_threshold      <= CRIT_THRESHOLD_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_VOLTAGE_FACTOR:          cfg.voltage_factor          <= pwdata[FACTOR_W-1:0];
        REG_CHARGING_VOLTAGE_FACTOR: cfg.charging_voltage_factor <= pwdata[FACTOR_W-1:0];
        REG_LOW_THRESHOLD:           cfg.low_threshold           <= pwdata[THR_W-1:0];
        REG_CRITICAL_THRESHOLD:      cfg.critical_threshold      <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_VOLTAGE_FACTOR:          prdata = APB_DW'(cfg.voltage_factor);
      REG_CHARGING_VOLTAGE_FACTOR: prdata = APB_DW'(cfg.charging_voltage_factor);
      REG_LOW_THRESHOLD:           prdata = APB_DW'(cfg.low_threshold);
      REG_CRITICAL_THRESHOLD:      prdata = APB_DW'(cfg.critical_threshold);
      default:                     prdata = '0;
    endcase
  end

  blm_ctrl #(
    .DIV_W (DIV_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  blm_datapath #(
    .ADC_BITS (ADC_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .cfg                (cfg),
    .adc_sample         (adc_sample),
    .charger_level      (charger_level),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .charger_event      (charger_event),
    .battery_event      (battery_event),
    .voltage_centivolts (voltage_centivolts),
    .is_charging        (is_charging),
    .is_low             (is_low),
    .is_critical        (is_critical),
    .lowest_sample      (lowest_sample)
  );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the battery level monitor: handshake driver, monitor and predictor.
`timescale 1ns / 1ps
module tb_top;
  import blm_pkg::*;

  localparam int ADC_W       = 12;
  localparam int CENTI_SCALE = 10000;
  localparam int PHASE_TICKS = 510;
  localparam int HOLD_CYCLES = 400;
  localparam int WDOG_LIMIT  = 4000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [ADC_W-1:0] sample;
    logic             chg;
  } tick_t;

  typedef struct packed {
    logic [1:0]        chg_evt;
    logic [1:0]        bat_evt;
    logic [VOLT_W-1:0] volt;
    logic              charging;
    logic              low;
    logic              crit;
    logic [ADC_W-1:0]  lowest;
  } report_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [ADC_W-1:0]    adc_sample = '0;
  logic                charger_level = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          charger_event;
  logic [1:0]          battery_event;
  logic [VOLT_W-1:0]   voltage_centivolts;
  logic                is_charging;
  logic                is_low;
  logic                is_critical;
  logic [ADC_W-1:0]    lowest_sample;

  // register shadow and tracking state of the predictor
  cfg_t             cfg;
  logic             seen_chg = 1'b0;
  logic             low_flagged = 1'b0;
  logic             crit_flagged = 1'b0;
  logic [ADC_W-1:0] min_seen = '1;

  tick_t   tick_q[$];
  report_t report_q[$];
  int      n_queued = 0;
  int      n_taken = 0;
  int      n_err = 0;
  int      send_idle = 0;
  int      recv_idle = 0;
  int      hold_left = 0;
  logic    hold_req = 1'b0;
  logic    hold_done = 1'b0;
  int      quiet_cycles = 0;

  // battery trajectory for the random part
  int      bat_lvl = 3200;
  logic    trend_chg = 1'b0;

  battery_level_monitor #(.ADC_BITS(ADC_W)) u_top (
    .clk                (clk),
    .rst                (rst),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .adc_sample         (adc_sample),
    .charger_level      (charger_level),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .charger_event      (charger_event),
    .battery_event      (battery_event),
    .voltage_centivolts (voltage_centivolts),
    .is_charging        (is_charging),
    .is_low             (is_low),
    .is_critical        (is_critical),
    .lowest_sample      (lowest_sample)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic report_t predict_report(input tick_t t);
    report_t          r;
    logic [FACTOR_W-1:0] f;
    int unsigned      q;
    r          = '0;
    r.charging = t.chg;
    r.low      = t.sample < cfg.low_threshold;
    r.crit     = t.sample < cfg.critical_threshold;
    if (t.chg || t.sample < min_seen) min_seen = t.sample;
    r.lowest = min_seen;
    if (t.chg && !seen_chg) r.chg_evt = CHG_EVT_CONNECT;
    else if (!t.chg && seen_chg) r.chg_evt = CHG_EVT_DISCONNECT;
    else r.chg_evt = CHG_EVT_NONE;
    seen_chg  = t.chg;
    r.bat_evt = BAT_EVT_NONE;
    if (!t.chg) begin
      // critical wins when both thresholds are crossed on one tick
      if (!crit_flagged && r.crit) begin
        crit_flagged = 1'b1;
        r.bat_evt    = BAT_EVT_CRITICAL;
      end else if (!low_flagged && r.low) begin
        low_flagged = 1'b1;
        r.bat_evt   = BAT_EVT_LOW;
      end
    end else begin
      low_flagged  = 1'b0;
      crit_flagged = 1'b0;
    end
    f = t.chg ? cfg.charging_voltage_factor : cfg.voltage_factor;
    if (f == '0) begin
      r.volt = VOLT_MAX;
    end else begin
      q      = (CENTI_SCALE * t.sample) / f;
      r.volt = (q > VOLT_MAX) ? VOLT_MAX : q[VOLT_W-1:0];
    end
    return r;
  endfunction

  function automatic tick_t next_tick();
    tick_t t;
    int    r;
    int    s;
    int    thr;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      // noise: any sample, any charger level
      t.sample = ADC_W'($urandom_range(0, 4095));
      t.chg    = 1'($urandom_range(0, 1));
    end else begin
      if ($urandom_range(0, 99) < 6) trend_chg = !trend_chg;
      if (trend_chg) bat_lvl = bat_lvl + int'($urandom_range(0, 60));
      else bat_lvl = bat_lvl - int'($urandom_range(0, 40));
      if (bat_lvl > 4095) begin
        bat_lvl   = 4095;
        trend_chg = 1'b0;
      end
      if (bat_lvl < 0) begin
        bat_lvl   = 0;
        trend_chg = 1'b1;
      end
      s = bat_lvl + int'($urandom_range(0, 40)) - 20;
      if (r < 20) begin
        thr = $urandom_range(0, 1) ? int'(cfg.low_threshold) : int'(cfg.critical_threshold);
        s   = thr + int'($urandom_range(0, 2)) - 1;
      end
      if (s < 0) s = 0;
      if (s > 4095) s = 4095;
      t.sample = s[ADC_W-1:0];
      t.chg    = trend_chg;
    end
    return t;
  endfunction

  task automatic queue_tick(input logic [ADC_W-1:0] sample, input logic chg);
    tick_t t;
    t.sample = sample;
    t.chg    = chg;
    tick_q.push_back(t);
    n_queued++;
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [APB_DW-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_VOLTAGE_FACTOR:          cfg.voltage_factor          = val[FACTOR_W-1:0];
      REG_CHARGING_VOLTAGE_FACTOR: cfg.charging_voltage_factor = val[FACTOR_W-1:0];
      REG_LOW_THRESHOLD:           cfg.low_threshold           = val[THR_W-1:0];
      REG_CRITICAL_THRESHOLD:      cfg.critical_threshold      = val[THR_W-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (n_taken != n_queued || report_q.size() != 0) @(negedge clk);
  endtask

  // driver: hold the payload until the transfer, then offer the next tick or idle
  always @(posedge clk) begin : drive_blk
    tick_t t;
    if (rst) begin
      in_valid      <= 1'b0;
      adc_sample    <= '0;
      charger_level <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (tick_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        t = tick_q.pop_front();
        in_valid      <= 1'b1;
        adc_sample    <= t.sample;
        charger_level <= t.chg;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random back-pressure, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(0, 99) >= recv_idle;
    end
  end

  // monitor: check output transfers first, then predict the accepted tick
  always @(posedge clk) begin : mon_blk
    report_t got;
    report_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = {charger_event, battery_event, voltage_centivolts, is_charging,
               is_low, is_critical, lowest_sample};
        if (report_q.size() == 0) begin
          n_err++;
          if (n_err <= 10)
            $display("%0t: result with no tick outstanding: %p", $realtime, got);
        end else begin
          want = report_q.pop_front();
          if (got.chg_evt !== want.chg_evt || got.bat_evt !== want.bat_evt ||
              got.volt !== want.volt || got.charging !== want.charging ||
              got.low !== want.low || got.crit !== want.crit ||
              got.lowest !== want.lowest) begin
            n_err++;
            if (n_err <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected chg_evt=%0d bat_evt=%0d volt=%0d chg=%0b low=%0b crit=%0b min=%0d",
                       want.chg_evt, want.bat_evt, want.volt, want.charging, want.low,
                       want.crit, want.lowest);
              $display("  actual   chg_evt=%0d bat_evt=%0d volt=%0d chg=%0b low=%0b crit=%0b min=%0d",
                       got.chg_evt, got.bat_evt, got.volt, got.charging, got.low,
                       got.crit, got.lowest);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        report_q.push_back(predict_report({adc_sample, charger_level}));
        n_taken++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : seq_blk
    int          p;
    int          k;
    logic [31:0] lo;
    logic [31:0] cr;
    tick_t       nt;
    cfg.voltage_factor          = VOLTAGE_FACTOR_RST;
    cfg.charging_voltage_factor = VOLTAGE_FACTOR_RST;
    cfg.low_threshold           = LOW_THRESHOLD_RST;
    cfg.critical_threshold      = CRIT_THRESHOLD_RST;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // charging factor of one saturates every charging tick with a sample of 7 or more
    cfg_write(REG_VOLTAGE_FACTOR, 32'd7200);
    cfg_write(REG_CHARGING_VOLTAGE_FACTOR, 32'd1);
    cfg_write(REG_LOW_THRESHOLD, 32'd2650);
    cfg_write(REG_CRITICAL_THRESHOLD, 32'd2500);
    queue_tick(12'd3000, 1'b0);
    queue_tick(12'd2600, 1'b0);
    queue_tick(12'd2400, 1'b0);
    queue_tick(12'd2400, 1'b0);
    queue_tick(12'd4095, 1'b1);
    queue_tick(12'd0, 1'b1);
    queue_tick(12'd0, 1'b1);
    queue_tick(12'd2000, 1'b0);
    queue_tick(12'd2000, 1'b0);
    queue_tick(12'd4095, 1'b0);
    queue_tick(12'd0, 1'b0);
    queue_tick(12'd1, 1'b1);
    queue_tick(12'd7, 1'b1);
    queue_tick(12'd2650, 1'b0);
    queue_tick(12'd2649, 1'b0);
    queue_tick(12'd2500, 1'b0);
    queue_tick(12'd2499, 1'b0);
    queue_tick(12'd4095, 1'b1);
    queue_tick(12'd2499, 1'b0);
    wait_drained();

    // zero factor with junk in the upper data bits, widest factor, threshold extremes
    cfg_write(REG_VOLTAGE_FACTOR, 32'hABCD_0000);
    cfg_write(REG_CHARGING_VOLTAGE_FACTOR, 32'd65535);
    cfg_write(REG_LOW_THRESHOLD, 32'd4095);
    cfg_write(REG_CRITICAL_THRESHOLD, 32'd0);
    queue_tick(12'd4095, 1'b0);
    queue_tick(12'd4094, 1'b0);
    queue_tick(12'd0, 1'b0);
    queue_tick(12'd4095, 1'b1);
    queue_tick(12'd0, 1'b1);
    queue_tick(12'd2730, 1'b0);
    wait_drained();

    for (p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle = 24;
          recv_idle = 59;
          lo = $urandom_range(2400, 3200);
          cr = $urandom_range(2000, lo);
          cfg_write(REG_VOLTAGE_FACTOR, $urandom_range(3000, 12000));
          cfg_write(REG_CHARGING_VOLTAGE_FACTOR, $urandom_range(3000, 12000));
          cfg_write(REG_LOW_THRESHOLD, lo);
          cfg_write(REG_CRITICAL_THRESHOLD, cr);
        end
        1: begin
          send_idle = 59;
          recv_idle = 24;
          cfg_write(REG_VOLTAGE_FACTOR, 32'd65535);
          cfg_write(REG_CHARGING_VOLTAGE_FACTOR, 32'd0);
          cfg_write(REG_LOW_THRESHOLD, 32'd4095);
          cfg_write(REG_CRITICAL_THRESHOLD, 32'd0);
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
          cfg_write(REG_VOLTAGE_FACTOR, $urandom);
          cfg_write(REG_CHARGING_VOLTAGE_FACTOR, 32'd1);
          cfg_write(REG_LOW_THRESHOLD, $urandom);
          cfg_write(REG_CRITICAL_THRESHOLD, $urandom);
        end
      endcase
      bat_lvl   = 3200;
      trend_chg = 1'b0;
      for (k = 0; k < PHASE_TICKS; k++) begin
        nt = next_tick();
        queue_tick(nt.sample, nt.chg);
      end
      // hold the output off with the sender still pushing, so the block stalls its input
      if (p == 2) hold_req = 1'b1;
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_err == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
